>>> src/shta_pkg.sv
// Package for the symbol hash table: sizes, item structs, status codes and
// the controller/datapath command and status bundles. No dependencies.
package shta_pkg;

  localparam int SLOT_BITS      = 12;
  localparam int SLOT_COUNT     = 1 << SLOT_BITS;
  localparam int ARENA_BYTES    = 128 * 1024;
  localparam int PROBE_LIMIT    = 8;
  localparam int MAX_NAME_BYTES = 16'hFFFF;

  localparam int FILL_W = $clog2(ARENA_BYTES + 1);
  localparam int STEP_W = $clog2(PROBE_LIMIT + 1);
  localparam int KEY_W  = 32;
  localparam int OFF_W  = 17;
  localparam int SIZE_W = 16;
  localparam int LEN_W  = 17;
  localparam int ROW_W  = KEY_W + OFF_W + SIZE_W;

  localparam logic [31:0] FIB_MULT = 32'd2654435761;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e_t;

  typedef enum logic [2:0] {
    ST_STORED      = 3'd0,
    ST_KNOWN       = 3'd1,
    ST_INVALID     = 3'd2,
    ST_ARENA_FULL  = 3'd3,
    ST_WINDOW_FULL = 3'd4,
    ST_FOUND       = 3'd5,
    ST_NOT_FOUND   = 3'd6
  } status_e_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_MEM  = 2'd1,
    SRC_FILL = 2'd2
  } res_src_t;

  typedef struct packed {
    logic              operation;
    logic [KEY_W-1:0]  address;
    logic [LEN_W-1:0]  name_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [OFF_W-1:0]  arena_offset;
    logic [SIZE_W-1:0] name_bytes;
  } out_item_t;

  typedef struct packed {
    logic      load_in;
    logic      hash_en;
    logic      rd_inc;
    logic      step_inc;
    logic      clr_wr;
    logic      slot_wr;
    logic      res_load;
    status_e_t res_code;
    res_src_t  res_src;
  } dp_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic addr_zero;
    logic len_bad;
    logic hit;
    logic empty;
    logic last;
    logic arena_ok;
    logic clr_last;
  } dp_stat_t;

endpackage

>>> src/symbol_hash_table_with_arena.sv
// Top level of the symbol hash table with name arena: joins the controller
// and the datapath. Depends on shta_pkg, shta_ctrl and shta_datapath.
//
// After reset the block runs a clearing pass over the 4096-slot memory,
// one slot a cycle, and holds busy high until the pass ends. An item is
// taken when start is high and busy is low; its single result appears on
// out_item for exactly one cycle with out_valid high and must be taken then,
// as the block cannot be stalled. A rejected insert or a lookup of address 0
// is answered straight from the hash state; otherwise the block hashes
// the address, issues the first read, probes k slots (1 to 8) and passes
// through a write state when a slot is written. The probe loop reads one
// slot of the slot memory per cycle, and busy falls in the cycle after the
// result strobe.
module symbol_hash_table_with_arena (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  shta_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output shta_pkg::out_item_t  out_item
);
  import shta_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  shta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  shta_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

>>> src/shta_datapath.sv
// Datapath of the symbol hash table: slot memory, clearing counter, hash,
// probe counters, arena fill and result register. Depends on shta_pkg.
module shta_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  shta_pkg::in_item_t in_item,
  input  shta_pkg::dp_cmd_t  cmd,
  output shta_pkg::dp_stat_t stat,
  output shta_pkg::out_item_t out_item
);
  import shta_pkg::*;

  logic [ROW_W-1:0]       mem [SLOT_COUNT];
  logic [ROW_W-1:0]       rd_q;
  logic [SLOT_BITS-1:0]   rd_addr;
  logic [SLOT_BITS-1:0]   wr_addr;
  logic [ROW_W-1:0]       wr_data;
  logic                   wr_en;

  in_item_t               item_r;
  logic [SLOT_BITS-1:0]   home_r;
  logic [2*SLOT_BITS-1:0] product;
  logic [STEP_W-1:0]      step_r;
  logic [STEP_W-1:0]      rd_step_r;
  logic [SLOT_BITS-1:0]   clr_cnt_r;
  logic [FILL_W-1:0]      fill_r;
  logic [FILL_W:0]        fill_sum;
  out_item_t              res_r;
  logic [KEY_W-1:0]       rd_key;

  assign product  = item_r.address[SLOT_BITS-1:0] * FIB_MULT[SLOT_BITS-1:0];
  assign rd_addr  = home_r + SLOT_BITS'(rd_step_r);
  assign wr_addr  = cmd.clr_wr ? clr_cnt_r : home_r + SLOT_BITS'(step_r);
  assign wr_data  = cmd.clr_wr ? '0 : {item_r.address, OFF_W'(fill_r),
                                       item_r.name_length[SIZE_W-1:0]};
  assign wr_en    = cmd.clr_wr | cmd.slot_wr;
  assign rd_key   = rd_q[ROW_W-1 -: KEY_W];
  assign fill_sum = {1'b0, fill_r} + (FILL_W + 1)'(item_r.name_length);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      item_r <= in_item;
    end
    if (cmd.hash_en) begin
      home_r <= product[SLOT_BITS-1:0];
    end
    if (cmd.res_load) begin
      res_r.status <= cmd.res_code;
      unique case (cmd.res_src)
        SRC_MEM: begin
          res_r.arena_offset <= rd_q[SIZE_W +: OFF_W];
          res_r.name_bytes   <= rd_q[SIZE_W-1:0];
        end
        SRC_FILL: begin
          res_r.arena_offset <= OFF_W'(fill_r);
          res_r.name_bytes   <= item_r.name_length[SIZE_W-1:0];
        end
        default: begin
          res_r.arena_offset <= '0;
          res_r.name_bytes   <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      rd_step_r <= '0;
      clr_cnt_r <= '0;
      fill_r    <= '0;
    end else begin
      if (cmd.hash_en) begin
        step_r    <= '0;
        rd_step_r <= '0;
      end else begin
        if (cmd.step_inc) begin
          step_r <= step_r + 1'b1;
        end
        if (cmd.rd_inc) begin
          rd_step_r <= rd_step_r + 1'b1;
        end
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.slot_wr) begin
        fill_r <= fill_sum[FILL_W-1:0];
      end
    end
  end

  assign stat.is_lookup = (item_r.operation == OP_LOOKUP);
  assign stat.addr_zero = (item_r.address == '0);
  assign stat.len_bad   = (item_r.name_length == '0) ||
                          (item_r.name_length > LEN_W'(MAX_NAME_BYTES));
  assign stat.hit       = (rd_key == item_r.address);
  assign stat.empty     = (rd_key == '0);
  assign stat.last      = (step_r == STEP_W'(PROBE_LIMIT - 1));
  assign stat.arena_ok  = (fill_sum <= (FILL_W + 1)'(ARENA_BYTES));
  assign stat.clr_last  = &clr_cnt_r;

  assign out_item = res_r;

endmodule

>>> src/shta_ctrl.sv
// Controller of the symbol hash table: sequences the clearing pass, hashing,
// probing, slot write and result strobe. Depends on shta_pkg.
module shta_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  input  shta_pkg::dp_stat_t stat,
  output shta_pkg::dp_cmd_t  cmd
);
  import shta_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_ISSUE = 7'b0001000,
    S_PROBE = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_code = ST_NOT_FOUND;
    cmd.res_src  = SRC_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_HASH;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_HASH: begin
        if (stat.is_lookup && stat.addr_zero) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_DONE;
        end else if (!stat.is_lookup && (stat.addr_zero || stat.len_bad)) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_INVALID;
          state_nxt    = S_DONE;
        end else begin
          cmd.hash_en = 1'b1;
          state_nxt   = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.rd_inc = 1'b1;
        state_nxt  = S_PROBE;
      end
      S_PROBE: begin
        cmd.rd_inc = 1'b1;
        if (stat.hit) begin
          cmd.res_load = 1'b1;
          if (stat.is_lookup) begin
            cmd.res_code = ST_FOUND;
            cmd.res_src  = SRC_MEM;
          end else begin
            cmd.res_code = ST_KNOWN;
          end
          state_nxt = S_DONE;
        end else if (stat.empty) begin
          if (!stat.is_lookup && stat.arena_ok) begin
            state_nxt = S_WRITE;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_code = stat.is_lookup ? ST_NOT_FOUND : ST_ARENA_FULL;
            state_nxt    = S_DONE;
          end
        end else if (stat.last) begin
          cmd.res_load = 1'b1;
          if (stat.is_lookup) begin
            cmd.res_code = ST_NOT_FOUND;
          end else begin
            cmd.res_code = stat.arena_ok ? ST_WINDOW_FULL : ST_ARENA_FULL;
          end
          state_nxt = S_DONE;
        end else begin
          cmd.step_inc = 1'b1;
        end
      end
      S_WRITE: begin
        cmd.slot_wr  = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_code = ST_STORED;
        cmd.res_src  = SRC_FILL;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule
